// File: rtl/core/gcd_pkg.sv
// ============================================================================
// gcd_pkg
// Shared types and constants of the gamepad command decoder: field widths,
// button, edge and pulse bit positions, register indexes and the structs that
// travel between the decoder's modules.
// ============================================================================
package gcd_pkg;

    // Field widths.
    localparam int BUTTON_W  = 16;
    localparam int AXIS_W    = 16;
    localparam int TIME_W    = 32;
    localparam int GAIN_W    = 12;
    localparam int TIMEOUT_W = 16;
    localparam int START_W   = 4;
    localparam int HOLD_W    = 5;
    localparam int DPAD_W    = 15;
    localparam int WRENCH_W  = 13;
    localparam int PULSE_W   = 7;
    localparam int EDGE_W    = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Button bit positions.
    localparam int BTN_HOLD      = 0;
    localparam int BTN_KILL      = 1;
    localparam int BTN_CLEARKILL = 2;
    localparam int BTN_RETRACT   = 4;
    localparam int BTN_DEPLOY    = 5;
    localparam int BTN_BACK      = 6;
    localparam int BTN_START     = 7;

    // Edge history bit positions.
    localparam int EDGE_BACK      = 0;
    localparam int EDGE_KILL      = 1;
    localparam int EDGE_CLEARKILL = 2;
    localparam int EDGE_HOLD      = 3;
    localparam int EDGE_RC        = 4;
    localparam int EDGE_AUTO      = 5;

    // Command pulse bit positions.
    localparam int PULSE_KILL      = 0;
    localparam int PULSE_CLEARKILL = 1;
    localparam int PULSE_HOLD      = 2;
    localparam int PULSE_RC        = 3;
    localparam int PULSE_AUTO      = 4;
    localparam int PULSE_RETRACT   = 5;
    localparam int PULSE_DEPLOY    = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRUSTER_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DPAD_THRESHOLD = 3'd5;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0]    LINEAR_GAIN_RST    = 12'd600;
    localparam logic [GAIN_W-1:0]    ANGULAR_GAIN_RST   = 12'd500;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST        = 16'd900;
    localparam logic [START_W-1:0]   START_LIMIT_RST    = 4'd5;
    localparam logic [HOLD_W-1:0]    THRUSTER_LIMIT_RST = 5'd10;
    localparam logic [DPAD_W-1:0]    DPAD_THRESHOLD_RST = 15'd29491;

    typedef struct packed {
        logic [GAIN_W-1:0]    linear_gain;
        logic [GAIN_W-1:0]    angular_gain;
        logic [TIMEOUT_W-1:0] timeout_seconds;
        logic [START_W-1:0]   start_hold_limit;
        logic [HOLD_W-1:0]    thruster_hold_limit;
        logic [DPAD_W-1:0]    dpad_threshold;
    } cfg_t;

    typedef struct packed {
        logic [BUTTON_W-1:0]      button_bits;
        logic signed [AXIS_W-1:0] axis_lateral;
        logic signed [AXIS_W-1:0] axis_forward;
        logic signed [AXIS_W-1:0] axis_turn;
        logic signed [AXIS_W-1:0] axis_dpad;
        logic [TIME_W-1:0]        arrival_seconds;
    } sample_t;

    typedef struct packed {
        logic [PULSE_W-1:0] command_pulses;
        logic               is_active;
        logic               timed_out;
        logic               wrench_published;
    } decision_t;

endpackage

// File: rtl/core/gcd_scale.sv
// ============================================================================
// gcd_scale
// Multiplies one signed axis by an unsigned gain, shifts the product right
// arithmetically by the number of fraction bits and saturates it to the
// wrench width.
// ============================================================================
module gcd_scale
    import gcd_pkg::*;
#(
    parameter int FRAC_BITS = 15
)
(
    input  logic signed [AXIS_W-1:0]   axis,
    input  logic [GAIN_W-1:0]          gain,
    output logic signed [WRENCH_W-1:0] result
);

    localparam int PROD_W = AXIS_W + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((2 ** (WRENCH_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] shifted;

    always_comb
    begin
        product = PROD_W'(axis) * $signed({1'b0, gain});
        shifted = product >>> FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            result = SAT_MAX[WRENCH_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            result = SAT_MIN[WRENCH_W-1:0];
        end
        else
        begin
            result = shifted[WRENCH_W-1:0];
        end
    end

endmodule

// File: rtl/core/gcd_ctrl.sv
// ============================================================================
// gcd_ctrl
// Decoder state and command logic: stored sample, inactivity timeout, edge
// history, hold counters and the active flag. Produces the decision for the
// sample presented while fire is high and updates the state at that edge.
// ============================================================================
module gcd_ctrl
    import gcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  sample_t   sample,
    input  cfg_t      cfg,
    output decision_t decision
);

    localparam logic [START_W-1:0] START_SAT = '1;
    localparam logic [HOLD_W-1:0]  HOLD_SAT  = '1;

    logic [BUTTON_W-1:0] prev_buttons_reg, prev_buttons_next;
    logic [AXIS_W-1:0]   prev_lat_reg, prev_lat_next;
    logic [AXIS_W-1:0]   prev_fwd_reg, prev_fwd_next;
    logic [AXIS_W-1:0]   prev_turn_reg, prev_turn_next;
    logic [AXIS_W-1:0]   prev_dpad_reg, prev_dpad_next;
    logic [TIME_W-1:0]   prev_arrival_reg, prev_arrival_next;
    logic                have_prev_reg, have_prev_next;
    logic [EDGE_W-1:0]   edge_hist_reg, edge_hist_next;
    logic [START_W-1:0]  start_cnt_reg, start_cnt_next;
    logic [HOLD_W-1:0]   retract_cnt_reg, retract_cnt_next;
    logic [HOLD_W-1:0]   deploy_cnt_reg, deploy_cnt_next;
    logic                active_reg, active_next;

    logic                   same;
    logic [TIME_W-1:0]      elapsed;
    logic                   late;
    logic signed [AXIS_W:0] dpad_wide;
    logic signed [AXIS_W:0] thr_pos;
    logic signed [AXIS_W:0] thr_neg;
    logic [EDGE_W-1:0]      edges;
    logic [EDGE_W-1:0]      rise;
    logic [PULSE_W-1:0]     pulses;
    logic                   timeout_hit;
    logic                   published;

    always_comb
    begin
        same = (sample.button_bits == prev_buttons_reg)
            && (sample.axis_lateral == prev_lat_reg)
            && (sample.axis_forward == prev_fwd_reg)
            && (sample.axis_turn == prev_turn_reg)
            && (sample.axis_dpad == prev_dpad_reg);
        elapsed = sample.arrival_seconds - prev_arrival_reg;
        late    = elapsed > {{(TIME_W - TIMEOUT_W){1'b0}}, cfg.timeout_seconds};

        dpad_wide = {sample.axis_dpad[AXIS_W-1], sample.axis_dpad};
        thr_pos   = $signed({2'b00, cfg.dpad_threshold});
        thr_neg   = -thr_pos;

        edges                 = '0;
        edges[EDGE_BACK]      = sample.button_bits[BTN_BACK];
        edges[EDGE_KILL]      = sample.button_bits[BTN_KILL];
        edges[EDGE_CLEARKILL] = sample.button_bits[BTN_CLEARKILL];
        edges[EDGE_HOLD]      = sample.button_bits[BTN_HOLD];
        edges[EDGE_RC]        = dpad_wide > thr_pos;
        edges[EDGE_AUTO]      = dpad_wide < thr_neg;

        prev_buttons_next = prev_buttons_reg;
        prev_lat_next     = prev_lat_reg;
        prev_fwd_next     = prev_fwd_reg;
        prev_turn_next    = prev_turn_reg;
        prev_dpad_next    = prev_dpad_reg;
        prev_arrival_next = prev_arrival_reg;
        have_prev_next    = have_prev_reg;
        edge_hist_next    = edge_hist_reg;
        start_cnt_next    = start_cnt_reg;
        retract_cnt_next  = retract_cnt_reg;
        deploy_cnt_next   = deploy_cnt_reg;
        active_next       = active_reg;
        timeout_hit       = 1'b0;
        published         = 1'b0;
        pulses            = '0;
        rise              = '0;

        // An unchanged sample that comes in late while active resets the
        // block and leaves the stored sample alone; otherwise it is stored.
        if (have_prev_reg && same && active_reg && late)
        begin
            timeout_hit      = 1'b1;
            edge_hist_next   = '0;
            start_cnt_next   = '0;
            retract_cnt_next = '0;
            deploy_cnt_next  = '0;
            have_prev_next   = 1'b0;
            active_next      = 1'b0;
        end
        else
        begin
            have_prev_next    = 1'b1;
            prev_buttons_next = sample.button_bits;
            prev_lat_next     = sample.axis_lateral;
            prev_fwd_next     = sample.axis_forward;
            prev_turn_next    = sample.axis_turn;
            prev_dpad_next    = sample.axis_dpad;
            prev_arrival_next = sample.arrival_seconds;
        end

        if (edges[EDGE_BACK] && !edge_hist_next[EDGE_BACK])
        begin
            edge_hist_next   = '0;
            start_cnt_next   = '0;
            retract_cnt_next = '0;
            deploy_cnt_next  = '0;
            have_prev_next   = 1'b0;
            active_next      = 1'b0;
        end
        else
        begin
            if (sample.button_bits[BTN_START] && (start_cnt_next != START_SAT))
            begin
                start_cnt_next = start_cnt_next + START_W'(1);
            end
            if (start_cnt_next > cfg.start_hold_limit)
            begin
                edge_hist_next   = '0;
                start_cnt_next   = '0;
                retract_cnt_next = '0;
                deploy_cnt_next  = '0;
                have_prev_next   = 1'b0;
                active_next      = 1'b1;
            end
            if (active_next)
            begin
                if (!sample.button_bits[BTN_RETRACT])
                begin
                    retract_cnt_next = '0;
                end
                else if (retract_cnt_next != HOLD_SAT)
                begin
                    retract_cnt_next = retract_cnt_next + HOLD_W'(1);
                end
                if (!sample.button_bits[BTN_DEPLOY])
                begin
                    deploy_cnt_next = '0;
                end
                else if (deploy_cnt_next != HOLD_SAT)
                begin
                    deploy_cnt_next = deploy_cnt_next + HOLD_W'(1);
                end

                // Retract wins when both holds are past the limit.
                priority if (retract_cnt_next > cfg.thruster_hold_limit)
                begin
                    pulses[PULSE_RETRACT] = 1'b1;
                    retract_cnt_next      = '0;
                end
                else if (deploy_cnt_next > cfg.thruster_hold_limit)
                begin
                    pulses[PULSE_DEPLOY] = 1'b1;
                    deploy_cnt_next      = '0;
                end
                else
                begin
                    // Neither hold is past the limit, so no thruster pulse.
                end

                rise                    = edges & ~edge_hist_next;
                pulses[PULSE_KILL]      = rise[EDGE_KILL];
                pulses[PULSE_CLEARKILL] = rise[EDGE_CLEARKILL];
                pulses[PULSE_HOLD]      = rise[EDGE_HOLD];
                pulses[PULSE_RC]        = rise[EDGE_RC];
                pulses[PULSE_AUTO]      = rise[EDGE_AUTO];
                edge_hist_next          = edges;
                published               = 1'b1;
            end
        end

        decision.command_pulses   = pulses;
        decision.is_active        = active_next;
        decision.timed_out        = timeout_hit;
        decision.wrench_published = published;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            prev_lat_reg     <= '0;
            prev_fwd_reg     <= '0;
            prev_turn_reg    <= '0;
            prev_dpad_reg    <= '0;
            prev_arrival_reg <= '0;
            have_prev_reg    <= 1'b0;
            edge_hist_reg    <= '0;
            start_cnt_reg    <= '0;
            retract_cnt_reg  <= '0;
            deploy_cnt_reg   <= '0;
            active_reg       <= 1'b0;
        end
        else if (fire)
        begin
            prev_buttons_reg <= prev_buttons_next;
            prev_lat_reg     <= prev_lat_next;
            prev_fwd_reg     <= prev_fwd_next;
            prev_turn_reg    <= prev_turn_next;
            prev_dpad_reg    <= prev_dpad_next;
            prev_arrival_reg <= prev_arrival_next;
            have_prev_reg    <= have_prev_next;
            edge_hist_reg    <= edge_hist_next;
            start_cnt_reg    <= start_cnt_next;
            retract_cnt_reg  <= retract_cnt_next;
            deploy_cnt_reg   <= deploy_cnt_next;
            active_reg       <= active_next;
        end
    end

endmodule

// File: rtl/core/gamepad_command_decoder.sv
// ============================================================================
// gamepad_command_decoder
// Turns gamepad samples into command pulses and a scaled force and torque.
// Path: input register, then result register; a downstream stall holds both.
// Throughput: one request per cycle unless the output stalls; the decoder
// state loop and three 16x12 multipliers all sit in the single stage
// between the two registers.
// Reset: asynchronous, active low; configuration returns to its defaults and
// the decoder to inactive with no stored sample. No clearing pass is needed.
// ============================================================================
module gamepad_command_decoder
    import gcd_pkg::*;
#(
    parameter int AXIS_FRAC_BITS = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Configuration write port.
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data,

    // Sample request channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [BUTTON_W-1:0]        button_bits,
    input  logic signed [AXIS_W-1:0]   axis_lateral,
    input  logic signed [AXIS_W-1:0]   axis_forward,
    input  logic signed [AXIS_W-1:0]   axis_turn,
    input  logic signed [AXIS_W-1:0]   axis_dpad,
    input  logic [TIME_W-1:0]          arrival_seconds,

    // Result request channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [WRENCH_W-1:0] force_x,
    output logic signed [WRENCH_W-1:0] force_y,
    output logic signed [WRENCH_W-1:0] torque_z,
    output logic                       wrench_published,
    output logic [PULSE_W-1:0]         command_pulses,
    output logic                       is_active,
    output logic                       timed_out
);

    // Configuration registers. Writes must come only while the decoder is idle
    // (the block does not enforce it); they are taken directly with no handshake.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_gain         <= LINEAR_GAIN_RST;
            cfg_reg.angular_gain        <= ANGULAR_GAIN_RST;
            cfg_reg.timeout_seconds     <= TIMEOUT_RST;
            cfg_reg.start_hold_limit    <= START_LIMIT_RST;
            cfg_reg.thruster_hold_limit <= THRUSTER_LIMIT_RST;
            cfg_reg.dpad_threshold      <= DPAD_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINEAR_GAIN:    cfg_reg.linear_gain <= cfg_data[GAIN_W-1:0];
                REG_ANGULAR_GAIN:   cfg_reg.angular_gain <= cfg_data[GAIN_W-1:0];
                REG_TIMEOUT:        cfg_reg.timeout_seconds <= cfg_data[TIMEOUT_W-1:0];
                REG_START_LIMIT:    cfg_reg.start_hold_limit <= cfg_data[START_W-1:0];
                REG_THRUSTER_LIMIT: cfg_reg.thruster_hold_limit <= cfg_data[HOLD_W-1:0];
                REG_DPAD_THRESHOLD: cfg_reg.dpad_threshold <= cfg_data[DPAD_W-1:0];
                default:            ;
            endcase
        end
    end

    // Pipeline handshake. The result register blocks only when it holds a
    // result that the downstream side is stalling. The input register then
    // holds its request, and a new request is stalled only if the input
    // register is also occupied. Otherwise both stages move every cycle.
    logic    in_valid_reg;
    sample_t in_sample_reg;
    logic    out_blocked;
    logic    in_take;
    logic    fire;

    assign out_blocked = out_valid && out_stall;
    assign in_stall    = in_valid_reg && out_blocked;
    assign in_take     = in_valid && !in_stall;
    assign fire        = in_valid_reg && !out_blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Sample payload; needs no reset because in_valid_reg qualifies it.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg.button_bits     <= button_bits;
            in_sample_reg.axis_lateral    <= axis_lateral;
            in_sample_reg.axis_forward    <= axis_forward;
            in_sample_reg.axis_turn       <= axis_turn;
            in_sample_reg.axis_dpad       <= axis_dpad;
            in_sample_reg.arrival_seconds <= arrival_seconds;
        end
    end

    // Decoder state and command decisions.
    decision_t decision;

    gcd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .sample   (in_sample_reg),
        .cfg      (cfg_reg),
        .decision (decision)
    );

    // Wrench scaling. The forward axis drives force_x and the lateral axis
    // drives force_y; both use the force gain, the turn axis uses the torque
    // gain.
    logic signed [WRENCH_W-1:0] scaled_x;
    logic signed [WRENCH_W-1:0] scaled_y;
    logic signed [WRENCH_W-1:0] scaled_z;

    gcd_scale #(.FRAC_BITS(AXIS_FRAC_BITS)) u_scale_x
    (
        .axis   (in_sample_reg.axis_forward),
        .gain   (cfg_reg.linear_gain),
        .result (scaled_x)
    );

    gcd_scale #(.FRAC_BITS(AXIS_FRAC_BITS)) u_scale_y
    (
        .axis   (in_sample_reg.axis_lateral),
        .gain   (cfg_reg.linear_gain),
        .result (scaled_y)
    );

    gcd_scale #(.FRAC_BITS(AXIS_FRAC_BITS)) u_scale_z
    (
        .axis   (in_sample_reg.axis_turn),
        .gain   (cfg_reg.angular_gain),
        .result (scaled_z)
    );

    // Result register. When the active path did not complete the wrench is
    // cleared to zero rather than carrying the scaled values.
    logic                       out_valid_reg;
    logic signed [WRENCH_W-1:0] force_x_reg, force_x_next;
    logic signed [WRENCH_W-1:0] force_y_reg, force_y_next;
    logic signed [WRENCH_W-1:0] torque_z_reg, torque_z_next;
    decision_t                  decision_reg;

    always_comb
    begin
        if (decision.wrench_published)
        begin
            force_x_next  = scaled_x;
            force_y_next  = scaled_y;
            torque_z_next = scaled_z;
        end
        else
        begin
            force_x_next  = '0;
            force_y_next  = '0;
            torque_z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            force_x_reg  <= force_x_next;
            force_y_reg  <= force_y_next;
            torque_z_reg <= torque_z_next;
            decision_reg <= decision;
        end
    end

    assign out_valid        = out_valid_reg;
    assign force_x          = force_x_reg;
    assign force_y          = force_y_reg;
    assign torque_z         = torque_z_reg;
    assign wrench_published = decision_reg.wrench_published;
    assign command_pulses   = decision_reg.command_pulses;
    assign is_active        = decision_reg.is_active;
    assign timed_out        = decision_reg.timed_out;

endmodule
